// ===== hdl/tss_pkg.sv =====
// shared types, codes and constants of the turbine start/stop sequencer
package tss_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned TickW    = 10;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned SpeedW   = 15;
  localparam int unsigned TempW    = 16;
  localparam int unsigned RateW    = 15;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 17;

  // mode codes as seen on the result channel
  localparam logic [ModeW-1:0] MODE_CODE_OFF      = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_STARTING = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_RUNNING  = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_STOPPING = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_FAULT    = 3'd4;

  typedef enum logic [4:0] {
    MODE_OFF      = 5'b00001,
    MODE_STARTING = 5'b00010,
    MODE_RUNNING  = 5'b00100,
    MODE_STOPPING = 5'b01000,
    MODE_FAULT    = 5'b10000
  } mode_e;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK      = 3'd0,
    FUNC_START     = 3'd1,
    FUNC_STOP      = 3'd2,
    FUNC_SET_BLEED = 3'd3,
    FUNC_SET_GEN   = 3'd4
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RUNNING_SPEED   = 4'd0,
    CFG_SPEED_RATE      = 4'd1,
    CFG_START_DURATION  = 4'd2,
    CFG_RUNNING_TEMP    = 4'd3,
    CFG_OFF_TEMP        = 4'd4,
    CFG_TEMP_RATE       = 4'd5,
    CFG_OVERSPEED_LIMIT = 4'd6,
    CFG_OVERTEMP_LIMIT  = 4'd7
  } cfg_idx_e;

  // register reset values
  localparam logic [SpeedW-1:0]        RST_RUNNING_SPEED   = 15'd25600;
  localparam logic [RateW-1:0]         RST_SPEED_RATE      = 15'd427;
  localparam logic [ElapsedW-1:0]      RST_START_DURATION  = 17'd61440;
  localparam logic signed [TempW-1:0]  RST_RUNNING_TEMP    = 16'sd6400;
  localparam logic signed [TempW-1:0]  RST_OFF_TEMP        = 16'sd240;
  localparam logic [RateW-1:0]         RST_TEMP_RATE       = 15'd960;
  localparam logic [SpeedW-1:0]        RST_OVERSPEED_LIMIT = 15'd27392;
  localparam logic signed [TempW-1:0]  RST_OVERTEMP_LIMIT  = 16'sd11200;

  // clamp and threshold values
  localparam logic signed [TempW-1:0]  SPEED_MAX      = 16'sd30720;
  localparam logic signed [TempW-1:0]  SPEED_STOP_THR = 16'sd256;
  localparam logic signed [TempW-1:0]  TEMP_MIN       = -16'sd960;
  localparam logic signed [TempW-1:0]  TEMP_MAX       = 16'sd19200;
  localparam logic [ElapsedW-1:0]      ELAPSED_MAX    = 17'd131071;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] c;
    unique case (m)
      MODE_OFF:      c = MODE_CODE_OFF;
      MODE_STARTING: c = MODE_CODE_STARTING;
      MODE_RUNNING:  c = MODE_CODE_RUNNING;
      MODE_STOPPING: c = MODE_CODE_STOPPING;
      MODE_FAULT:    c = MODE_CODE_FAULT;
      default:       c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/tss_if.sv =====
// handshake channels of the sequencer: command input, result output, register write
interface tss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::FuncW-1:0]     func;
  logic [tss_pkg::TickW-1:0]     tick_length;
  logic                          switch_on;

  modport source (output valid, output func, output tick_length, output switch_on,
                  input ready);
  modport sink   (input valid, input func, input tick_length, input switch_on,
                  output ready);
endinterface

interface tss_out_if;
  logic                              valid;
  logic                              ready;
  logic [tss_pkg::ModeW-1:0]         mode;
  logic [tss_pkg::SpeedW-1:0]        speed;
  logic signed [tss_pkg::TempW-1:0]  exhaust_temp;
  logic                              bleed_available;
  logic                              power_available;
  logic                              fault_latched;

  modport source (output valid, output mode, output speed, output exhaust_temp,
                  output bleed_available, output power_available, output fault_latched,
                  input ready);
  modport sink   (input valid, input mode, input speed, input exhaust_temp,
                  input bleed_available, input power_available, input fault_latched,
                  output ready);
endinterface

interface tss_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::CfgIdxW-1:0]   index;
  logic [tss_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/turbine_start_stop_sequencer_top.sv =====
// Turbine start/stop sequencer: takes one command or tick per cycle and returns the
// resulting mode, speed, exhaust temperature and status. An accepted item is held in an
// input register while the whole state update (two 15x10 ramp products, the mode
// transition, clamping and the overspeed/overtemperature check) is done in a single pass;
// the new state is then taken into the result register, which drives the output channel.
// One item is accepted per cycle as long as results are taken; the result register stalls
// the input register, and the input register stalls the input channel. Register writes are
// taken in every cycle and should be issued only while no item is in flight.
module turbine_start_stop_sequencer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  tss_in_if.sink        in_i,
  tss_cfg_if.sink       cfg_i,
  tss_out_if.source     out_o
);

  // configuration registers
  logic [tss_pkg::SpeedW-1:0]        running_speed_q;
  logic [tss_pkg::RateW-1:0]         speed_rate_q;
  logic [tss_pkg::ElapsedW-1:0]      start_duration_q;
  logic signed [tss_pkg::TempW-1:0]  running_temp_q;
  logic signed [tss_pkg::TempW-1:0]  off_temp_q;
  logic [tss_pkg::RateW-1:0]         temp_rate_q;
  logic [tss_pkg::SpeedW-1:0]        overspeed_limit_q;
  logic signed [tss_pkg::TempW-1:0]  overtemp_limit_q;

  // input register
  logic                         in_valid_q;
  logic [tss_pkg::FuncW-1:0]    func_q;
  logic [tss_pkg::TickW-1:0]    tick_q;
  logic                         switch_q;

  // sequencer state, which also forms the result register
  tss_pkg::mode_e                    mode_q, mode_d;
  logic [tss_pkg::SpeedW-1:0]        speed_q, speed_d;
  logic signed [tss_pkg::TempW-1:0]  temp_q, temp_d;
  logic [tss_pkg::ElapsedW-1:0]      elapsed_q, elapsed_d;
  logic                              bleed_q, bleed_d;
  logic                              gen_q, gen_d;
  logic                              fault_q, fault_d;
  logic                              out_valid_q;

  logic                              advance;
  logic signed [tss_pkg::TempW-1:0]  spd_cur;
  logic signed [tss_pkg::TempW-1:0]  spd_tgt;
  logic signed [tss_pkg::TempW-1:0]  tmp_tgt;
  logic signed [tss_pkg::TempW-1:0]  spd_ramp;
  logic signed [tss_pkg::TempW-1:0]  tmp_ramp;
  logic signed [tss_pkg::TempW-1:0]  spd_clamp;
  logic signed [tss_pkg::TempW-1:0]  tmp_clamp;
  logic [tss_pkg::ElapsedW:0]        elapsed_sum;
  logic [tss_pkg::ElapsedW-1:0]      elapsed_sat;
  logic                              run_targets;

  // input register moves into the state once the result slot is free
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_speed_q   <= tss_pkg::RST_RUNNING_SPEED;
      speed_rate_q      <= tss_pkg::RST_SPEED_RATE;
      start_duration_q  <= tss_pkg::RST_START_DURATION;
      running_temp_q    <= tss_pkg::RST_RUNNING_TEMP;
      off_temp_q        <= tss_pkg::RST_OFF_TEMP;
      temp_rate_q       <= tss_pkg::RST_TEMP_RATE;
      overspeed_limit_q <= tss_pkg::RST_OVERSPEED_LIMIT;
      overtemp_limit_q  <= tss_pkg::RST_OVERTEMP_LIMIT;
    end else if (cfg_i.valid) begin
      unique case (tss_pkg::cfg_idx_e'(cfg_i.index))
        tss_pkg::CFG_RUNNING_SPEED:   running_speed_q   <= cfg_i.data[tss_pkg::SpeedW-1:0];
        tss_pkg::CFG_SPEED_RATE:      speed_rate_q      <= cfg_i.data[tss_pkg::RateW-1:0];
        tss_pkg::CFG_START_DURATION:  start_duration_q  <= cfg_i.data;
        tss_pkg::CFG_RUNNING_TEMP:    running_temp_q    <= signed'(cfg_i.data[tss_pkg::TempW-1:0]);
        tss_pkg::CFG_OFF_TEMP:        off_temp_q        <= signed'(cfg_i.data[tss_pkg::TempW-1:0]);
        tss_pkg::CFG_TEMP_RATE:       temp_rate_q       <= cfg_i.data[tss_pkg::RateW-1:0];
        tss_pkg::CFG_OVERSPEED_LIMIT: overspeed_limit_q <= cfg_i.data[tss_pkg::SpeedW-1:0];
        tss_pkg::CFG_OVERTEMP_LIMIT:  overtemp_limit_q  <= signed'(cfg_i.data[tss_pkg::TempW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q   <= in_i.func;
      tick_q   <= in_i.tick_length;
      switch_q <= in_i.switch_on;
    end
  end

  // targets by mode
  always_comb begin
    run_targets = (mode_q == tss_pkg::MODE_STARTING) || (mode_q == tss_pkg::MODE_RUNNING);
    spd_cur     = signed'({1'b0, speed_q});
    spd_tgt     = run_targets ? signed'({1'b0, running_speed_q}) : '0;
    tmp_tgt     = run_targets ? running_temp_q : off_temp_q;
  end

  tss_ramp u_speed_ramp (
    .cur_i    (spd_cur),
    .target_i (spd_tgt),
    .rate_i   (speed_rate_q),
    .tick_i   (tick_q),
    .next_o   (spd_ramp)
  );

  tss_ramp u_temp_ramp (
    .cur_i    (temp_q),
    .target_i (tmp_tgt),
    .rate_i   (temp_rate_q),
    .tick_i   (tick_q),
    .next_o   (tmp_ramp)
  );

  always_comb begin
    mode_d    = mode_q;
    speed_d   = speed_q;
    temp_d    = temp_q;
    elapsed_d = elapsed_q;
    bleed_d   = bleed_q;
    gen_d     = gen_q;
    fault_d   = fault_q;

    elapsed_sum = {1'b0, elapsed_q} + (tss_pkg::ElapsedW + 1)'(tick_q);
    elapsed_sat = elapsed_sum[tss_pkg::ElapsedW] ? tss_pkg::ELAPSED_MAX
                                                 : elapsed_sum[tss_pkg::ElapsedW-1:0];

    // speed ramp never goes below zero, only the upper clamp matters
    spd_clamp = (spd_ramp > tss_pkg::SPEED_MAX) ? tss_pkg::SPEED_MAX : spd_ramp;
    if (tmp_ramp < tss_pkg::TEMP_MIN)      tmp_clamp = tss_pkg::TEMP_MIN;
    else if (tmp_ramp > tss_pkg::TEMP_MAX) tmp_clamp = tss_pkg::TEMP_MAX;
    else                                   tmp_clamp = tmp_ramp;

    case (tss_pkg::func_e'(func_q))
      tss_pkg::FUNC_TICK: begin
        speed_d = spd_clamp[tss_pkg::SpeedW-1:0];
        // temperature is frozen in fault shutdown
        if (mode_q != tss_pkg::MODE_FAULT) temp_d = tmp_clamp;
        unique case (mode_q)
          tss_pkg::MODE_STARTING: begin
            elapsed_d = elapsed_sat;
            if (elapsed_sat >= start_duration_q) mode_d = tss_pkg::MODE_RUNNING;
          end
          tss_pkg::MODE_STOPPING: begin
            if (spd_ramp < tss_pkg::SPEED_STOP_THR) begin
              mode_d  = tss_pkg::MODE_OFF;
              bleed_d = 1'b0;
              gen_d   = 1'b0;
            end
          end
          tss_pkg::MODE_FAULT: begin
            bleed_d = 1'b0;
            gen_d   = 1'b0;
          end
          default: ;
        endcase
        if ((spd_clamp > signed'({1'b0, overspeed_limit_q})) ||
            (temp_d > overtemp_limit_q)) begin
          mode_d  = tss_pkg::MODE_FAULT;
          fault_d = 1'b1;
        end
      end
      tss_pkg::FUNC_START: begin
        if (mode_q == tss_pkg::MODE_OFF) begin
          mode_d    = tss_pkg::MODE_STARTING;
          elapsed_d = '0;
        end
      end
      tss_pkg::FUNC_STOP: begin
        if (run_targets) mode_d = tss_pkg::MODE_STOPPING;
      end
      tss_pkg::FUNC_SET_BLEED: bleed_d = switch_q;
      tss_pkg::FUNC_SET_GEN:   gen_d   = switch_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tss_pkg::MODE_OFF;
      speed_q     <= '0;
      temp_q      <= tss_pkg::RST_OFF_TEMP;
      elapsed_q   <= '0;
      bleed_q     <= 1'b0;
      gen_q       <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q    <= mode_d;
        speed_q   <= speed_d;
        temp_q    <= temp_d;
        elapsed_q <= elapsed_d;
        bleed_q   <= bleed_d;
        gen_q     <= gen_d;
        fault_q   <= fault_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state holds while a result waits, so it drives the result channel directly
  assign out_o.valid           = out_valid_q;
  assign out_o.mode            = tss_pkg::mode_code(mode_q);
  assign out_o.speed           = speed_q;
  assign out_o.exhaust_temp    = temp_q;
  assign out_o.bleed_available = (mode_q == tss_pkg::MODE_RUNNING) && bleed_q;
  assign out_o.power_available = (mode_q == tss_pkg::MODE_RUNNING) && gen_q;
  assign out_o.fault_latched   = fault_q;

endmodule

// ===== hdl/tss_ramp.sv =====
// rate-limited move of a signed value toward a target over one tick
module tss_ramp (
  input  logic signed [tss_pkg::TempW-1:0] cur_i,
  input  logic signed [tss_pkg::TempW-1:0] target_i,
  input  logic [tss_pkg::RateW-1:0]        rate_i,
  input  logic [tss_pkg::TickW-1:0]        tick_i,
  output logic signed [tss_pkg::TempW-1:0] next_o
);

  localparam int unsigned ProdW = tss_pkg::RateW + tss_pkg::TickW;
  localparam int unsigned DiffW = tss_pkg::TempW + 1;

  logic [ProdW-1:0]        prod;
  logic [tss_pkg::RateW-1:0] step;
  logic signed [DiffW-1:0] cur_x;
  logic signed [DiffW-1:0] tgt_x;
  logic signed [DiffW-1:0] step_x;
  logic signed [DiffW-1:0] diff_up;
  logic signed [DiffW-1:0] diff_dn;

  always_comb begin
    prod    = ProdW'(rate_i) * ProdW'(tick_i);
    // per-second rate times tick in 1/1024 s, truncated
    step    = prod[ProdW-1:tss_pkg::TickW];
    cur_x   = {cur_i[tss_pkg::TempW-1], cur_i};
    tgt_x   = {target_i[tss_pkg::TempW-1], target_i};
    step_x  = signed'({{(DiffW - tss_pkg::RateW){1'b0}}, step});
    diff_up = tgt_x - cur_x;
    diff_dn = cur_x - tgt_x;
    next_o  = target_i;
    // the stepped value lies between cur and target, so it fits
    if (tgt_x > cur_x) begin
      if (diff_up > step_x) next_o = tss_pkg::TempW'(cur_x + step_x);
    end else begin
      if (diff_dn > step_x) next_o = tss_pkg::TempW'(cur_x - step_x);
    end
  end

endmodule

// ===== tb/sv/tb_turbine_start_stop_sequencer_top.sv =====
// self-checking testbench of the turbine start/stop sequencer top level
module tb_turbine_start_stop_sequencer_top;
  import tss_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 6;

  // func codes the block ignores
  localparam logic [FuncW-1:0] FuncUnusedLo = 3'd5;
  localparam logic [FuncW-1:0] FuncUnusedHi = 3'd7;
  // register index with nothing behind it
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd15;

  typedef struct {
    logic [ModeW-1:0]        mode;
    logic [SpeedW-1:0]       speed;
    logic signed [TempW-1:0] temp;
    logic                    bleed_av;
    logic                    power_av;
    logic                    fault;
  } status_t;

  typedef enum {SET_HIGH, SET_LOW, SET_RANDOM, SET_TRIP, SET_TRIP_LOW} setting_kind_e;

  class sequencer_scoreboard;
    int tgt_speed, speed_rate, start_len, run_temp, off_temp, temp_rate;
    int speed_limit, temp_limit;
    logic [ModeW-1:0] mode;
    int speed, temp, elapsed;
    bit bleed_open, gen_online, faulted;
    status_t status_q[$];
    int errors;

    function new();
      tgt_speed   = int'(RST_RUNNING_SPEED);
      speed_rate  = int'(RST_SPEED_RATE);
      start_len   = int'(RST_START_DURATION);
      run_temp    = int'(RST_RUNNING_TEMP);
      off_temp    = int'(RST_OFF_TEMP);
      temp_rate   = int'(RST_TEMP_RATE);
      speed_limit = int'(RST_OVERSPEED_LIMIT);
      temp_limit  = int'(RST_OVERTEMP_LIMIT);
      mode        = MODE_CODE_OFF;
      speed       = 0;
      temp        = int'(RST_OFF_TEMP);
      elapsed     = 0;
      bleed_open  = 0;
      gen_online  = 0;
      faulted     = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_RUNNING_SPEED:   tgt_speed   = int'(d[SpeedW-1:0]);
        CFG_SPEED_RATE:      speed_rate  = int'(d[RateW-1:0]);
        CFG_START_DURATION:  start_len   = int'(d);
        CFG_RUNNING_TEMP:    run_temp    = int'($signed(d[TempW-1:0]));
        CFG_OFF_TEMP:        off_temp    = int'($signed(d[TempW-1:0]));
        CFG_TEMP_RATE:       temp_rate   = int'(d[RateW-1:0]);
        CFG_OVERSPEED_LIMIT: speed_limit = int'(d[SpeedW-1:0]);
        CFG_OVERTEMP_LIMIT:  temp_limit  = int'($signed(d[TempW-1:0]));
        default: ;
      endcase
    endfunction

    // move toward target by at most rate * len / 1024, truncated
    function int step_toward(int cur, int target, int rate, int len);
      int stp;
      stp = (rate * len) >> 10;
      if (target > cur) return (target - cur > stp) ? cur + stp : target;
      return (cur - target > stp) ? cur - stp : target;
    endfunction

    function void advance(int len);
      int speed_tgt, temp_tgt;
      bit move_temp;
      speed_tgt = 0;
      temp_tgt  = off_temp;
      move_temp = 1;
      case (mode)
        MODE_CODE_STARTING: begin
          elapsed += len;
          if (elapsed > int'(ELAPSED_MAX)) elapsed = int'(ELAPSED_MAX);
          speed_tgt = tgt_speed;
          temp_tgt  = run_temp;
        end
        MODE_CODE_RUNNING: begin
          speed_tgt = tgt_speed;
          temp_tgt  = run_temp;
        end
        MODE_CODE_FAULT: move_temp = 0;
        default: ;
      endcase
      speed = step_toward(speed, speed_tgt, speed_rate, len);
      if (move_temp) temp = step_toward(temp, temp_tgt, temp_rate, len);
      if (mode == MODE_CODE_STARTING && elapsed >= start_len) begin
        mode = MODE_CODE_RUNNING;
      end else if (mode == MODE_CODE_STOPPING && speed < int'(SPEED_STOP_THR)) begin
        mode       = MODE_CODE_OFF;
        bleed_open = 0;
        gen_online = 0;
      end else if (mode == MODE_CODE_FAULT) begin
        bleed_open = 0;
        gen_online = 0;
      end
      if (speed < 0) speed = 0;
      if (speed > int'(SPEED_MAX)) speed = int'(SPEED_MAX);
      if (temp < int'(TEMP_MIN)) temp = int'(TEMP_MIN);
      if (temp > int'(TEMP_MAX)) temp = int'(TEMP_MAX);
      if (speed > speed_limit || temp > temp_limit) begin
        mode    = MODE_CODE_FAULT;
        faulted = 1;
      end
    endfunction

    function void note_command(logic [FuncW-1:0] f, logic [TickW-1:0] len, logic sw);
      status_t s;
      case (f)
        FUNC_TICK: advance(int'(len));
        FUNC_START: begin
          if (mode == MODE_CODE_OFF) begin
            mode    = MODE_CODE_STARTING;
            elapsed = 0;
          end
        end
        FUNC_STOP: begin
          if (mode == MODE_CODE_STARTING || mode == MODE_CODE_RUNNING) mode = MODE_CODE_STOPPING;
        end
        FUNC_SET_BLEED: bleed_open = sw;
        FUNC_SET_GEN:   gen_online = sw;
        default: ;
      endcase
      s.mode     = mode;
      s.speed    = SpeedW'(speed);
      s.temp     = TempW'(temp);
      s.bleed_av = (mode == MODE_CODE_RUNNING) && bleed_open;
      s.power_av = (mode == MODE_CODE_RUNNING) && gen_online;
      s.fault    = faulted;
      status_q.push_back(s);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [ModeW-1:0] m, logic [SpeedW-1:0] spd,
                               logic signed [TempW-1:0] t, logic bl, logic pw, logic flt);
      status_t s;
      if (status_q.size() == 0) begin
        $error("status transfer with no command outstanding");
        errors++;
        return;
      end
      s = status_q.pop_front();
      check_field("mode", int'(s.mode), int'(m));
      check_field("speed", int'(s.speed), int'(spd));
      check_field("exhaust_temp", int'(s.temp), int'(t));
      check_field("bleed_available", int'(s.bleed_av), int'(bl));
      check_field("power_available", int'(s.power_av), int'(pw));
      check_field("fault_latched", int'(s.fault), int'(flt));
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tss_in_if  in_if();
  tss_out_if out_if();
  tss_cfg_if cfg_if();

  turbine_start_stop_sequencer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  sequencer_scoreboard sb;
  logic [CfgDataW-1:0] reg_vals [8];
  logic [15:0] ready_pattern = '1;
  logic [3:0]  ready_pos = '0;
  int          burst_left = 0;
  bit          sender_idles = 0;
  int          quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls on a rotating pattern
  always @(posedge clk_i) begin
    ready_pos    <= ready_pos + 4'd1;
    out_if.ready <= ready_pattern[ready_pos];
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_command(in_if.func, in_if.tick_length, in_if.switch_on);
      if (out_if.valid && out_if.ready)
        sb.check_status(out_if.mode, out_if.speed, out_if.exhaust_temp,
                        out_if.bleed_available, out_if.power_available, out_if.fault_latched);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(logic [FuncW-1:0] f, logic [TickW-1:0] len, logic sw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.func        <= f;
    in_if.tick_length <= len;
    in_if.switch_on   <= sw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    // let the monitor note the last transfer before counting what is outstanding
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_idx_e'(i);
      cfg_if.data  <= reg_vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    // a write to an unmapped index must change nothing
    cfg_if.index <= CfgIdxSpare;
    cfg_if.data  <= CfgDataW'($urandom);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_pacing();
    sender_idles = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) ready_pattern <= '1;
    else ready_pattern <= 16'($urandom) | 16'h0001;
  endtask

  function automatic logic [CfgDataW-1:0] temp_word(int lo, int hi);
    return CfgDataW'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic choose_settings(setting_kind_e k);
    reg_vals[CFG_RUNNING_SPEED]   = CfgDataW'($urandom);
    reg_vals[CFG_SPEED_RATE]      = $urandom_range(0, 1) ? CfgDataW'($urandom_range(50, 3000))
                                                         : CfgDataW'($urandom);
    reg_vals[CFG_START_DURATION]  = CfgDataW'($urandom_range(0, 8000));
    reg_vals[CFG_RUNNING_TEMP]    = $urandom_range(0, 1) ? temp_word(0, 19200)
                                                         : CfgDataW'($urandom);
    reg_vals[CFG_OFF_TEMP]        = $urandom_range(0, 1) ? temp_word(-960, 2000)
                                                         : CfgDataW'($urandom);
    reg_vals[CFG_TEMP_RATE]       = $urandom_range(0, 1) ? CfgDataW'($urandom_range(100, 5000))
                                                         : CfgDataW'($urandom);
    // limits above the clamps keep the turbine out of fault
    reg_vals[CFG_OVERSPEED_LIMIT] = CfgDataW'($urandom_range(30720, 32767));
    reg_vals[CFG_OVERTEMP_LIMIT]  = CfgDataW'($urandom_range(19200, 32767));
    case (k)
      SET_HIGH: begin
        reg_vals[CFG_RUNNING_SPEED]   = 17'h07FFF;
        reg_vals[CFG_SPEED_RATE]      = 17'h07FFF;
        reg_vals[CFG_START_DURATION]  = '0;
        reg_vals[CFG_RUNNING_TEMP]    = 17'h07FFF;
        reg_vals[CFG_OFF_TEMP]        = 17'h08000;
        reg_vals[CFG_TEMP_RATE]       = 17'h07FFF;
        reg_vals[CFG_OVERSPEED_LIMIT] = 17'h07FFF;
        reg_vals[CFG_OVERTEMP_LIMIT]  = 17'h07FFF;
      end
      SET_LOW: begin
        reg_vals[CFG_RUNNING_SPEED]   = '0;
        reg_vals[CFG_SPEED_RATE]      = '0;
        reg_vals[CFG_START_DURATION]  = '1;
        reg_vals[CFG_RUNNING_TEMP]    = temp_word(-960, -960);
        reg_vals[CFG_OFF_TEMP]        = temp_word(-960, -960);
        reg_vals[CFG_TEMP_RATE]       = '0;
        reg_vals[CFG_OVERSPEED_LIMIT] = CfgDataW'(30720);
        reg_vals[CFG_OVERTEMP_LIMIT]  = CfgDataW'(19200);
      end
      SET_TRIP: begin
        reg_vals[CFG_OVERSPEED_LIMIT] = CfgDataW'($urandom_range(0, 30720));
        reg_vals[CFG_OVERTEMP_LIMIT]  = temp_word(-960, 19200);
      end
      SET_TRIP_LOW: begin
        reg_vals[CFG_RUNNING_SPEED]   = '0;
        reg_vals[CFG_OVERSPEED_LIMIT] = '0;
        reg_vals[CFG_OVERTEMP_LIMIT]  = 17'h18000;
      end
      default: ;
    endcase
  endtask

  function automatic logic [TickW-1:0] pick_tick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TickW'($urandom_range(0, 1023));
      default: return TickW'($urandom_range(600, 1023));
    endcase
  endfunction

  task automatic run_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_item(FUNC_TICK, pick_tick_len(), 1'($urandom));
      else if (pick < 77)
        send_item(FUNC_START, TickW'($urandom), 1'($urandom));
      else if (pick < 79)
        send_item(FUNC_STOP, TickW'($urandom), 1'($urandom));
      else if (pick < 88)
        send_item(FUNC_SET_BLEED, TickW'($urandom), 1'($urandom));
      else if (pick < 97)
        send_item(FUNC_SET_GEN, TickW'($urandom), 1'($urandom));
      else
        send_item(FuncW'($urandom_range(FuncUnusedLo, FuncUnusedHi)), TickW'($urandom),
                  1'($urandom));
    end
  endtask

  task automatic run_directed();
    send_item(FuncUnusedLo, 10'd1023, 1'b1);
    send_item(FuncUnusedHi, 10'd0, 1'b0);
    send_item(FUNC_STOP, 10'd0, 1'b0);          // stop while off is ignored
    send_item(FUNC_TICK, 10'd0, 1'b0);
    send_item(FUNC_TICK, 10'd1023, 1'b0);
    send_item(FUNC_SET_BLEED, 10'd0, 1'b1);
    send_item(FUNC_SET_GEN, 10'd0, 1'b1);
    send_item(FUNC_START, 10'd0, 1'b0);
    send_item(FUNC_START, 10'd1023, 1'b1);      // already starting
    send_item(FUNC_TICK, 10'd0, 1'b0);
    send_item(FUNC_TICK, 10'd1, 1'b0);          // step truncates to zero
    repeat (3) send_item(FUNC_TICK, 10'd1023, 1'b1);
    send_item(FUNC_SET_BLEED, 10'd0, 1'b0);
    send_item(FUNC_STOP, 10'd0, 1'b0);
    send_item(FUNC_STOP, 10'd0, 1'b0);          // already stopping
    repeat (3) send_item(FUNC_TICK, 10'd1023, 1'b0);
    send_item(FUNC_START, 10'd0, 1'b0);
    send_item(FUNC_SET_GEN, 10'd1023, 1'b0);
  endtask

  initial begin
    setting_kind_e plan [8];
    plan = '{SET_HIGH, SET_LOW, SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM,
             SET_TRIP, SET_TRIP_LOW};
    sb = new();
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.func        <= FUNC_TICK;
    in_if.tick_length <= '0;
    in_if.switch_on   <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_RUNNING_SPEED;
    cfg_if.data       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_pacing();
    run_directed();
    run_random(205);
    drain();
    // fault settings come last since only reset leaves fault shutdown
    foreach (plan[p]) begin
      choose_settings(plan[p]);
      program_regs();
      set_pacing();
      run_random(205);
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
